/* design/rgcn_pkg.sv */
package rgcn_pkg;

   localparam int unsigned TABLE_DEPTH_DEF = 64;
   localparam int          ADDR_W          = 31;
   localparam int          FUNC_W          = 2;
   localparam int          STATUS_W        = 3;

   localparam logic [ADDR_W-1:0] RING_SIZE = 31'h7fff_ffff;

   localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_ROUTE   = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_NEAREST = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ABSENT     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_CLOSER = 3'd4;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_EXEC,
      S_DIST1,
      S_DIST2,
      S_DIST3,
      S_RESP
   } state_type;

   typedef struct packed {
      logic clear_wr;
      logic load;
      logic scan_rd;
      logic exec;
      logic dist1;
      logic dist2;
      logic dist3;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic addr_last;
      logic go_dist;
      logic rsp_busy;
   } stat_type;

endpackage

/* design/ring_greedy_closest_node_unit.sv */
// Ring closest-node table: holds up to TABLE_DEPTH unique 31-bit addresses in a memory
// with one write port and one read port and answers insert, remove, greedy route and
// nearest queries, one result word per request word. Every request scans the whole table
// one entry per cycle through the memory read port, then passes a drain step and an
// execute step; queries on a non-empty table then run the distance steps before the
// response step, which waits while a pending result has not been taken on rsp_ready. After
// reset a clearing pass over every entry runs with req_ready low. A result waits in an
// output register, so one request may be accepted while the previous result is still pending.
module ring_greedy_closest_node_unit #(
   parameter int unsigned TABLE_DEPTH = rgcn_pkg::TABLE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rgcn_pkg::FUNC_W-1:0]   req_func,
   input  logic [rgcn_pkg::ADDR_W-1:0]   req_target_addr,
   input  logic [rgcn_pkg::ADDR_W-1:0]   req_source_addr,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rgcn_pkg::STATUS_W-1:0] rsp_status,
   output logic [rgcn_pkg::ADDR_W-1:0]   rsp_next_node
);

   rgcn_pkg::cmd_type  cmd;
   rgcn_pkg::stat_type stat;

   rgcn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rgcn_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_func        (req_func),
      .req_target_addr (req_target_addr),
      .req_source_addr (req_source_addr),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_next_node   (rsp_next_node),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule

/* design/rgcn_ctrl.sv */
module rgcn_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rgcn_pkg::stat_type stat,
   output rgcn_pkg::cmd_type  cmd
);

   rgcn_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rgcn_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         rgcn_pkg::S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.addr_last) begin
               state_in = rgcn_pkg::S_IDLE;
            end
         end
         rgcn_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = rgcn_pkg::S_SCAN;
            end
         end
         rgcn_pkg::S_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (stat.addr_last) begin
               state_in = rgcn_pkg::S_DRAIN;
            end
         end
         rgcn_pkg::S_DRAIN: begin
            state_in = rgcn_pkg::S_EXEC;
         end
         rgcn_pkg::S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = stat.go_dist ? rgcn_pkg::S_DIST1 : rgcn_pkg::S_RESP;
         end
         rgcn_pkg::S_DIST1: begin
            cmd.dist1 = 1'b1;
            state_in  = rgcn_pkg::S_DIST2;
         end
         rgcn_pkg::S_DIST2: begin
            cmd.dist2 = 1'b1;
            state_in  = rgcn_pkg::S_DIST3;
         end
         rgcn_pkg::S_DIST3: begin
            cmd.dist3 = 1'b1;
            state_in  = rgcn_pkg::S_RESP;
         end
         rgcn_pkg::S_RESP: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = rgcn_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rgcn_pkg::S_CLEAR;
         end
      endcase
   end

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == rgcn_pkg::S_SCAN))
      else $error("accepted word did not start a scan");

   a_exec_branch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rgcn_pkg::S_EXEC) |=>
         (state_ff == rgcn_pkg::S_DIST1 || state_ff == rgcn_pkg::S_RESP))
      else $error("bad branch after execute");

endmodule

/* design/rgcn_datapath.sv */
module rgcn_datapath #(
   parameter int unsigned TABLE_DEPTH = rgcn_pkg::TABLE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [rgcn_pkg::FUNC_W-1:0]     req_func,
   input  logic [rgcn_pkg::ADDR_W-1:0]     req_target_addr,
   input  logic [rgcn_pkg::ADDR_W-1:0]     req_source_addr,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rgcn_pkg::STATUS_W-1:0]   rsp_status,
   output logic [rgcn_pkg::ADDR_W-1:0]     rsp_next_node,
   input  rgcn_pkg::cmd_type               cmd,
   output rgcn_pkg::stat_type              stat
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int KW = rgcn_pkg::ADDR_W;

   logic [KW:0]   mem_ram [TABLE_DEPTH];
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [KW:0]   mem_wdata;

   logic [AW-1:0] addr_ff, addr_in;
   logic          addr_last;
   logic [KW:0]   rd_data_ff;
   logic [AW-1:0] rd_idx_ff;
   logic          rd_vld_ff;

   logic [rgcn_pkg::FUNC_W-1:0] func_ff;
   logic [KW-1:0] tgt_ff, src_ff;

   logic          any_ff, found_ff, free_ff, has_s_ff, has_p_ff;
   logic [AW-1:0] found_idx_ff, free_idx_ff;
   logic [KW-1:0] kmin_ff, kmax_ff, succ_ff, pred_ff;

   logic [KW-1:0] cand_s_ff, cand_p_ff, cand_s_in, cand_p_in;
   logic [KW-1:0] dabs_s_ff, dabs_p_ff, dabs_src_ff;
   logic [KW-1:0] ring_s_ff, ring_p_ff, ring_src_ff;

   logic [rgcn_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [KW-1:0]                 res_node_ff, res_node_in;
   logic                          rsp_valid_ff;
   logic [rgcn_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [KW-1:0]                 rsp_node_ff;

   logic          rd_v;
   logic [KW-1:0] rd_k;
   logic          is_query;
   logic [KW-1:0] ch_node;
   logic [KW-1:0] ch_dist;

   function automatic logic [KW-1:0] abs_diff(input logic [KW-1:0] a, input logic [KW-1:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

   function automatic logic [KW-1:0] ring_min(input logic [KW-1:0] d);
      logic [KW-1:0] w;
      w        = rgcn_pkg::RING_SIZE - d;
      ring_min = (d < w) ? d : w;
   endfunction

   assign addr_last = (addr_ff == AW'(TABLE_DEPTH - 1));
   assign addr_in   = addr_last ? '0 : addr_ff + AW'(1);
   assign rd_v      = rd_data_ff[KW];
   assign rd_k      = rd_data_ff[KW-1:0];
   assign is_query  = func_ff[1];

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = '0;
      res_status_in = rgcn_pkg::ST_OK;
      res_node_in   = '0;
      if (cmd.clear_wr) begin
         mem_we = 1'b1;
      end else if (cmd.exec) begin
         unique case (func_ff)
            rgcn_pkg::FUNC_INSERT: begin
               if (!found_ff) begin
                  if (free_ff) begin
                     mem_we    = 1'b1;
                     mem_waddr = free_idx_ff;
                     mem_wdata = {1'b1, tgt_ff};
                  end else begin
                     res_status_in = rgcn_pkg::ST_FULL;
                  end
               end
            end
            rgcn_pkg::FUNC_REMOVE: begin
               if (found_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = found_idx_ff;
               end else begin
                  res_status_in = rgcn_pkg::ST_ABSENT;
               end
            end
            rgcn_pkg::FUNC_ROUTE, rgcn_pkg::FUNC_NEAREST: begin
               if (!any_ff) begin
                  res_status_in = rgcn_pkg::ST_EMPTY;
               end
            end
            default: begin
               res_status_in = rgcn_pkg::ST_OK;
            end
         endcase
      end
      ch_node = (ring_s_ff < ring_p_ff) ? cand_s_ff : cand_p_ff;
      ch_dist = (ring_s_ff < ring_p_ff) ? ring_s_ff : ring_p_ff;
      if (cmd.dist3) begin
         if ((func_ff == rgcn_pkg::FUNC_ROUTE) && !(ch_dist < ring_src_ff)) begin
            res_status_in = rgcn_pkg::ST_NOT_CLOSER;
         end else begin
            res_node_in = ch_node;
         end
      end
   end

   assign cand_s_in = has_s_ff ? succ_ff : kmin_ff;
   assign cand_p_in = has_p_ff ? pred_ff : kmax_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ram[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem_ram[addr_ff];
      rd_idx_ff  <= addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         any_ff       <= 1'b0;
         found_ff     <= 1'b0;
         free_ff      <= 1'b0;
         has_s_ff     <= 1'b0;
         has_p_ff     <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan_rd;
         if (cmd.clear_wr || cmd.scan_rd) begin
            addr_ff <= addr_in;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.load) begin
            any_ff   <= 1'b0;
            found_ff <= 1'b0;
            free_ff  <= 1'b0;
            has_s_ff <= 1'b0;
            has_p_ff <= 1'b0;
         end else if (rd_vld_ff) begin
            if (!rd_v) begin
               free_ff <= 1'b1;
            end else begin
               any_ff <= 1'b1;
               if (rd_k == tgt_ff) begin
                  found_ff <= 1'b1;
               end
               if (rd_k > tgt_ff) begin
                  has_s_ff <= 1'b1;
               end else begin
                  has_p_ff <= 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         tgt_ff  <= req_target_addr;
         src_ff  <= req_source_addr;
      end
      if (rd_vld_ff) begin
         if (!rd_v) begin
            if (!free_ff) begin
               free_idx_ff <= rd_idx_ff;
            end
         end else begin
            if (!any_ff || rd_k < kmin_ff) begin
               kmin_ff <= rd_k;
            end
            if (!any_ff || rd_k > kmax_ff) begin
               kmax_ff <= rd_k;
            end
            if (rd_k == tgt_ff && !found_ff) begin
               found_idx_ff <= rd_idx_ff;
            end
            if (rd_k > tgt_ff) begin
               if (!has_s_ff || rd_k < succ_ff) begin
                  succ_ff <= rd_k;
               end
            end else begin
               if (!has_p_ff || rd_k > pred_ff) begin
                  pred_ff <= rd_k;
               end
            end
         end
      end
      if (cmd.dist1) begin
         cand_s_ff   <= cand_s_in;
         cand_p_ff   <= cand_p_in;
         dabs_s_ff   <= abs_diff(cand_s_in, tgt_ff);
         dabs_p_ff   <= abs_diff(cand_p_in, tgt_ff);
         dabs_src_ff <= abs_diff(src_ff, tgt_ff);
      end
      if (cmd.dist2) begin
         ring_s_ff   <= ring_min(dabs_s_ff);
         ring_p_ff   <= ring_min(dabs_p_ff);
         ring_src_ff <= ring_min(dabs_src_ff);
      end
      if (cmd.exec || cmd.dist3) begin
         res_status_ff <= res_status_in;
         res_node_ff   <= res_node_in;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_node_ff   <= res_node_ff;
      end
   end

   assign stat.addr_last = addr_last;
   assign stat.go_dist   = is_query && any_ff;
   assign stat.rsp_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_next_node = rsp_node_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid_ff && !rsp_ready))
      else $error("pending result word overwritten");

   a_dist_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.dist1 |-> (any_ff && is_query))
      else $error("distance step on empty table or update");

endmodule
